>>> src/gtc_pkg.sv
// gtc_pkg: shared widths, constants, beat structs and control structs
// for the tilt conditioner; no dependencies
package gtc_pkg;

    localparam int MAG_W  = 15;   // q1.14 magnitude, at most 1.0
    localparam int SMAG_W = 16;   // raw stick magnitude, up to 32768
    localparam int NUM_W  = 30;   // divider numerator
    localparam int DEN_W  = 16;   // divider denominator
    localparam int SQ_W   = 30;   // squared vector length

    localparam logic [MAG_W-1:0]  ONE_Q14  = 15'd16384;
    localparam logic [DEN_W-1:0]  FULL_Q15 = 16'h8000;
    localparam logic [SQ_W-1:0]   ONE_SQ   = 30'h1000_0000;
    localparam logic [13:0]       DZ_RESET = 14'd2458;

    // divider operations: stick conditioning or unit-circle scaling, per axis
    localparam logic [1:0] OP_CX = 2'd0;
    localparam logic [1:0] OP_CY = 2'd1;
    localparam logic [1:0] OP_SX = 2'd2;
    localparam logic [1:0] OP_SY = 2'd3;

    typedef struct packed {
        logic [3:0]         key_dirs;
        logic [2:0]         key_buttons;
        logic               pad_present;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic [2:0]         pad_buttons;
    } t_in;

    typedef struct packed {
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic [2:0]         held_bits;
        logic [2:0]         pressed_bits;
    } t_out;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       div_load;
        logic [1:0] div_op;
        logic       pick_stick;
        logic       sq_x;
        logic       sq_y;
        logic       sqrt_start;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic need_clamp;
        logic out_free;
    } t_status;

endpackage

>>> src/gtc_div.sv
// gtc_div: restoring divider, one quotient bit per cycle
// depends on gtc_pkg; quotient known to fit in MAG_W bits
module gtc_div
    import gtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quo
);

    localparam logic [3:0] STEPS = 4'(MAG_W);

    logic [3:0]       r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [MAG_W-1:0] r_low;
    logic [MAG_W-1:0] r_quo;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    assign trial = {r_rem, r_low[MAG_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});
    assign n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STEPS;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 4'd1;
                r_done <= (r_cnt == 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper numerator bits are already below the divisor
            r_rem <= {1'b0, i_num[NUM_W-1:MAG_W]};
            r_low <= i_num[MAG_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_low <= {r_low[MAG_W-2:0], 1'b0};
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/gtc_isqrt.sv
// gtc_isqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on gtc_pkg; radicand below 2^30
module gtc_isqrt
    import gtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_rad,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    localparam logic [SQ_W-2:0] BIT_TOP = 29'h1000_0000;

    logic [SQ_W-2:0] r_bit;
    logic            r_done;
    logic [SQ_W-1:0] r_rad;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] sum;
    logic            fits;

    assign sum  = r_res + {1'b0, r_bit};
    assign fits = (r_rad >= sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bit <= BIT_TOP;
            end else if (r_bit != '0) begin
                r_bit  <= r_bit >> 2;
                r_done <= r_bit[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (fits) begin
                r_rad <= r_rad - sum;
                r_res <= {1'b0, r_res[SQ_W-1:1]} + {1'b0, r_bit};
            end else begin
                r_res <= {1'b0, r_res[SQ_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[MAG_W-1:0];

endmodule

>>> src/gtc_datapath.sv
// gtc_datapath: input capture, deadzone rescale, length check, clamp and output register
// depends on gtc_pkg, gtc_div and gtc_isqrt
module gtc_datapath
    import gtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [13:0] i_cfg_data,
    input  t_in        i_in_data,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    logic [13:0]       r_dz;
    logic              r_out_valid;
    logic [2:0]        r_prev;
    t_out              r_out;

    logic [MAG_W-1:0]  r_mag_x, r_mag_y;
    logic              r_neg_x, r_neg_y;
    logic [SMAG_W-1:0] r_smag_x, r_smag_y;
    logic              r_sneg_x, r_sneg_y;
    logic [MAG_W-1:0]  r_cmag_x, r_cmag_y;
    logic              r_pad;
    logic [2:0]        r_held;
    logic [SQ_W-1:0]   r_acc;

    logic [SMAG_W-1:0] dz16;
    logic [DEN_W-1:0]  span;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [MAG_W-1:0]  div_quo;
    logic              sqrt_done;
    logic [MAG_W-1:0]  root;
    logic [MAG_W-1:0]  mul_in;
    logic [SQ_W-1:0]   prod;
    logic [15:0]       sx_u, sy_u;
    logic [SMAG_W-1:0] sx_mag, sy_mag;
    logic              sy_neg;
    logic [15:0]       tx, ty;

    assign dz16 = {1'b0, r_dz, 1'b0};
    assign span = FULL_Q15 - dz16;

    // stick magnitudes; y is inverted with saturation at full scale
    assign sx_u   = i_in_data.stick_x;
    assign sy_u   = i_in_data.stick_y;
    assign sx_mag = sx_u[15] ? (~sx_u + 16'd1) : sx_u;
    assign sy_mag = (sy_u == 16'h8000) ? 16'd32767 : (sy_u[15] ? (~sy_u + 16'd1) : sy_u);
    assign sy_neg = !sy_u[15] && (sy_u != 16'd0);

    always_comb begin
        unique case (i_cmd.div_op)
            OP_CX: begin
                div_num = {16'(r_smag_x - dz16), 14'b0};
                div_den = span;
            end
            OP_CY: begin
                div_num = {16'(r_smag_y - dz16), 14'b0};
                div_den = span;
            end
            OP_SX: begin
                div_num = {1'b0, r_mag_x, 14'b0};
                div_den = {1'b0, root};
            end
            default: begin
                div_num = {1'b0, r_mag_y, 14'b0};
                div_den = {1'b0, root};
            end
        endcase
    end

    gtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    gtc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_rad   (r_acc),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign mul_in = i_cmd.sq_y ? r_mag_y : r_mag_x;
    assign prod   = {15'd0, mul_in} * {15'd0, mul_in};

    assign tx = r_neg_x ? (16'd0 - {1'b0, r_mag_x}) : {1'b0, r_mag_x};
    assign ty = r_neg_y ? (16'd0 - {1'b0, r_mag_y}) : {1'b0, r_mag_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz        <= DZ_RESET;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dz <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_held;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mag_x  <= (i_in_data.key_dirs[0] ^ i_in_data.key_dirs[1]) ? ONE_Q14 : '0;
            r_neg_x  <= i_in_data.key_dirs[0] & ~i_in_data.key_dirs[1];
            r_mag_y  <= (i_in_data.key_dirs[2] ^ i_in_data.key_dirs[3]) ? ONE_Q14 : '0;
            r_neg_y  <= i_in_data.key_dirs[3] & ~i_in_data.key_dirs[2];
            r_smag_x <= sx_mag;
            r_sneg_x <= sx_u[15];
            r_smag_y <= sy_mag;
            r_sneg_y <= sy_neg;
            r_pad    <= i_in_data.pad_present;
            r_held   <= i_in_data.key_buttons
                      | (i_in_data.pad_present ? i_in_data.pad_buttons : 3'd0);
        end
        if (i_cmd.div_load) begin
            unique case (i_cmd.div_op)
                OP_CX:   r_cmag_x <= (r_smag_x < dz16) ? '0 : div_quo;
                OP_CY:   r_cmag_y <= (r_smag_y < dz16) ? '0 : div_quo;
                OP_SX:   r_mag_x  <= div_quo;
                default: r_mag_y  <= div_quo;
            endcase
        end
        // stick wins only when present and out of the deadzone on some axis
        if (i_cmd.pick_stick && r_pad && (r_cmag_x != '0 || r_cmag_y != '0)) begin
            r_mag_x <= r_cmag_x;
            r_neg_x <= r_sneg_x;
            r_mag_y <= r_cmag_y;
            r_neg_y <= r_sneg_y;
        end
        if (i_cmd.sq_x) begin
            r_acc <= prod;
        end else if (i_cmd.sq_y) begin
            r_acc <= r_acc + prod;
        end
        if (i_cmd.finish) begin
            r_out.tilt_x       <= tx;
            r_out.tilt_y       <= ty;
            r_out.held_bits    <= r_held;
            r_out.pressed_bits <= r_held & ~r_prev;
        end
    end

    assign o_status.div_done   = div_done;
    assign o_status.sqrt_done  = sqrt_done;
    assign o_status.need_clamp = (r_acc > ONE_SQ);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken beat");

    a_cond_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_load && i_cmd.div_op == OP_CX) |=> (r_cmag_x <= ONE_Q14))
        else $error("conditioned stick x above full scale");

    a_clamp_on_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_load && i_cmd.div_op == OP_SY)
            |=> (r_mag_x <= ONE_Q14 && r_mag_y <= ONE_Q14))
        else $error("clamped tilt outside unit range");
`endif

endmodule

>>> src/gtc_ctrl.sv
// gtc_ctrl: sequencer for one frame: two rescales, length check, optional clamp
// depends on gtc_pkg; drives the datapath through t_cmd and reads t_status
module gtc_ctrl
    import gtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DXL  = 4'd1;
    localparam logic [3:0] S_DXW  = 4'd2;
    localparam logic [3:0] S_DYL  = 4'd3;
    localparam logic [3:0] S_DYW  = 4'd4;
    localparam logic [3:0] S_SEL  = 4'd5;
    localparam logic [3:0] S_SQX  = 4'd6;
    localparam logic [3:0] S_SQY  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_RTL  = 4'd9;
    localparam logic [3:0] S_RTW  = 4'd10;
    localparam logic [3:0] S_SXL  = 4'd11;
    localparam logic [3:0] S_SXW  = 4'd12;
    localparam logic [3:0] S_SYL  = 4'd13;
    localparam logic [3:0] S_SYW  = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DXL;
                end
            end
            S_DXL: begin
                o_cmd.div_op    = OP_CX;
                o_cmd.div_start = 1'b1;
                n_state         = S_DXW;
            end
            S_DXW: begin
                o_cmd.div_op = OP_CX;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DYL;
                end
            end
            S_DYL: begin
                o_cmd.div_op    = OP_CY;
                o_cmd.div_start = 1'b1;
                n_state         = S_DYW;
            end
            S_DYW: begin
                o_cmd.div_op = OP_CY;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.pick_stick = 1'b1;
                n_state          = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_state = i_status.need_clamp ? S_RTL : S_FIN;
            end
            S_RTL: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_RTW;
            end
            S_RTW: begin
                if (i_status.sqrt_done) begin
                    n_state = S_SXL;
                end
            end
            S_SXL: begin
                o_cmd.div_op    = OP_SX;
                o_cmd.div_start = 1'b1;
                n_state         = S_SXW;
            end
            S_SXW: begin
                o_cmd.div_op = OP_SX;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_SYL;
                end
            end
            S_SYL: begin
                o_cmd.div_op    = OP_SY;
                o_cmd.div_start = 1'b1;
                n_state         = S_SYW;
            end
            S_SYW: begin
                o_cmd.div_op = OP_SY;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DXW || r_state == S_DYW
                               || r_state == S_SXW || r_state == S_SYW))
        else $error("divider finished outside a wait state");

    a_sqrt_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.sqrt_done |-> (r_state == S_RTW))
        else $error("square root finished outside its wait state");
`endif

endmodule

>>> src/gamepad_tilt_conditioner_core.sv
// channel  direction  handshake                  beat
// in       input      i_in_valid / o_in_ready    t_in  i_in_data
// out      output     o_out_valid / i_out_ready  t_out o_out_data
// cfg      input      i_cfg_valid / o_cfg_ready  deadzone level, 14 bits
//
// one frame at a time: the next beat is taken only once the sequencer is done with the
// last; the shared 15-step divider runs twice per frame, four times when the tilt is
// clamped to the unit circle.
// the result sits in an output register, so the next beat is taken while it waits.
// synchronous active-low reset; deadzone returns to 2458, button history clears.
// config writes are always taken and are meant for an idle block.
//
// top level of the tilt conditioner; depends on gtc_pkg, gtc_ctrl, gtc_datapath
module gamepad_tilt_conditioner_core
    import gtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    gtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gtc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
